// ===== sv/imucal_pkg.sv =====
package imucal_pkg;

  // default saturation width of calibrated and filtered samples
  localparam int SAMPLE_WIDTH_DEF = 32;

  // port width of every sample field and offset register
  localparam int FIELD_W = 32;

  // rotated value plus offset always fits in one bit more than a field
  localparam int CAL_W = FIELD_W + 1;

  // filter delay state, signed Q16.32
  localparam int STATE_W = 48;

  localparam int NUM_AXES = 3;

  // low-pass coefficients, signed Q2.30, summing to 2^30
  localparam logic signed [31:0] COEF_C0 = 32'sd2071735500;
  localparam logic signed [31:0] COEF_C1 = -32'sd1000494913;
  localparam logic signed [31:0] COEF_C2 = 32'sd2501237;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_OFF_X  = 3'd0,
    CFG_GYRO_OFF_Y  = 3'd1,
    CFG_GYRO_OFF_Z  = 3'd2,
    CFG_ACCEL_OFF_X = 3'd3,
    CFG_ACCEL_OFF_Y = 3'd4,
    CFG_ACCEL_OFF_Z = 3'd5
  } cfg_idx_t;

  // filter control from the pipeline
  typedef struct packed {
    logic upd;     // beat moves into the result stage, advance the state
    logic primed;  // delay stages already loaded
  } lpf_ctl_t;

  // clamp a calibrated value to sat_w signed bits
  function automatic logic signed [CAL_W-1:0] sat_sample(
    input logic signed [CAL_W-1:0] v,
    input int                      sat_w
  );
    int                      w;
    logic signed [CAL_W-1:0] hi;
    logic signed [CAL_W-1:0] lo;
    w  = (sat_w < CAL_W) ? sat_w : CAL_W;
    hi = CAL_W'((64'sd1 <<< (w - 1)) - 64'sd1);
    lo = ~hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

// ===== sv/imucal_lpf.sv =====
module imucal_lpf
  import imucal_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  lpf_ctl_t                ctl,
  input  logic signed [CAL_W-1:0] cal_in,
  output logic [FIELD_W-1:0]      filt_out
);

  localparam int ACC_W = 84;
  localparam int RND_W = ACC_W - 30;
  localparam logic signed [ACC_W-1:0] RND_STATE = ACC_W'(64'sd1 <<< 29);
  localparam logic signed [STATE_W:0] RND_OUT = (STATE_W + 1)'(64'sd1 <<< 15);
  localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W - 1){1'b1}}};
  localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W - 1){1'b0}}};

  logic signed [STATE_W-1:0] y1_r, y2_r;
  logic signed [STATE_W-1:0] y1_nxt, y2_nxt;

  logic signed [31:0]        hi1, hi2;
  logic signed [16:0]        lo1, lo2;
  logic signed [63:0]        ph1, ph2;
  logic signed [48:0]        pl1, pl2;
  logic signed [55:0]        px;
  logic signed [ACC_W-1:0]   acc;
  logic signed [RND_W-1:0]   rnd;
  logic signed [STATE_W-1:0] y_new;
  logic signed [STATE_W:0]   prime_ext;
  logic signed [STATE_W-1:0] prime_val;
  logic signed [STATE_W:0]   out_rnd;
  logic signed [CAL_W-1:0]   out_q;
  logic signed [CAL_W-1:0]   out_sat;

  // split the state words so every state-word product stays within 32 by 32
  assign hi1 = y1_r[STATE_W-1:16];
  assign hi2 = y2_r[STATE_W-1:16];
  assign lo1 = {1'b0, y1_r[15:0]};
  assign lo2 = {1'b0, y2_r[15:0]};

  assign ph1 = 64'(hi1) * 64'(COEF_C0);
  assign ph2 = 64'(hi2) * 64'(COEF_C1);
  assign pl1 = 49'(lo1) * 49'(COEF_C0);
  assign pl2 = 49'(lo2) * 49'(COEF_C1);
  assign px  = 56'(cal_in) * 56'(COEF_C2);

  // exact Q18.62 sum, then round half up to Q16.32
  assign acc = ((ACC_W'(ph1) + ACC_W'(ph2) + ACC_W'(px)) <<< 16)
             + ACC_W'(pl1) + ACC_W'(pl2) + RND_STATE;
  assign rnd = acc[ACC_W-1:30];

  // state saturation to 48 bits
  always_comb begin
    if (rnd[RND_W-1:STATE_W-1] == {(RND_W - STATE_W + 1){rnd[STATE_W-1]}}) begin
      y_new = rnd[STATE_W-1:0];
    end else if (rnd[RND_W-1]) begin
      y_new = ST_MIN;
    end else begin
      y_new = ST_MAX;
    end
  end

  // priming value: input scaled to Q16.32, saturated
  assign prime_ext = {cal_in, 16'b0};
  always_comb begin
    if (prime_ext[STATE_W] == prime_ext[STATE_W-1]) begin
      prime_val = prime_ext[STATE_W-1:0];
    end else if (prime_ext[STATE_W]) begin
      prime_val = ST_MIN;
    end else begin
      prime_val = ST_MAX;
    end
  end

  // output rounding to Q16.16
  assign out_rnd = {y_new[STATE_W-1], y_new} + RND_OUT;
  assign out_q   = out_rnd[STATE_W:16];
  assign out_sat = sat_sample(out_q, SAMPLE_WIDTH);

  assign y1_nxt   = ctl.primed ? y_new : prime_val;
  assign y2_nxt   = ctl.primed ? y1_r  : prime_val;
  assign filt_out = ctl.primed ? out_sat[FIELD_W-1:0] : cal_in[FIELD_W-1:0];

  // delay stages
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      y1_r <= y1_nxt;
      y2_r <= y2_nxt;
    end
  end

endmodule

// ===== sv/imu_calibrate_and_lowpass.sv =====
// each input beat is registered in the calibration stage and then in the result stage
// throughput: one beat per cycle while out_stall is low; the filter recurrence closes
// in the result stage, one 32x32 and one 17x32 product per state word
// reset: synchronous active-low rst_n clears the pipeline valids, the primed flag
// and all offset registers; the first beat after reset primes the filters
module imu_calibrate_and_lowpass
  import imucal_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_idx,
  input  logic [FIELD_W-1:0]        cfg_wdata,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] in_raw_gyro_x,
  input  logic signed [FIELD_W-1:0] in_raw_gyro_y,
  input  logic signed [FIELD_W-1:0] in_raw_gyro_z,
  input  logic signed [FIELD_W-1:0] in_raw_accel_x,
  input  logic signed [FIELD_W-1:0] in_raw_accel_y,
  input  logic signed [FIELD_W-1:0] in_raw_accel_z,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] out_cal_gyro_x,
  output logic signed [FIELD_W-1:0] out_cal_gyro_y,
  output logic signed [FIELD_W-1:0] out_cal_gyro_z,
  output logic signed [FIELD_W-1:0] out_cal_accel_x,
  output logic signed [FIELD_W-1:0] out_cal_accel_y,
  output logic signed [FIELD_W-1:0] out_cal_accel_z,
  output logic signed [FIELD_W-1:0] out_filt_accel_x,
  output logic signed [FIELD_W-1:0] out_filt_accel_y,
  output logic signed [FIELD_W-1:0] out_filt_accel_z
);

  logic signed [FIELD_W-1:0] gyro_off_r  [NUM_AXES];
  logic signed [FIELD_W-1:0] accel_off_r [NUM_AXES];

  logic                      s1_valid_r;
  logic [FIELD_W-1:0]        gcal_r [NUM_AXES];
  logic signed [CAL_W-1:0]   acal_r [NUM_AXES];

  logic                      out_valid_r;
  logic                      primed_r;
  logic [FIELD_W-1:0]        gout_r [NUM_AXES];
  logic [FIELD_W-1:0]        aout_r [NUM_AXES];
  logic [FIELD_W-1:0]        fout_r [NUM_AXES];

  logic signed [CAL_W-1:0]   gsum [NUM_AXES];
  logic signed [CAL_W-1:0]   asum [NUM_AXES];
  logic [FIELD_W-1:0]        filt [NUM_AXES];

  logic                      out_adv;
  logic                      s1_adv;
  lpf_ctl_t                  lpf_ctl;

  // pipeline flow
  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;

  assign lpf_ctl.upd    = out_adv && s1_valid_r;
  assign lpf_ctl.primed = primed_r;

  // offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        gyro_off_r[i]  <= '0;
        accel_off_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GYRO_OFF_X:  gyro_off_r[0]  <= cfg_wdata;
        CFG_GYRO_OFF_Y:  gyro_off_r[1]  <= cfg_wdata;
        CFG_GYRO_OFF_Z:  gyro_off_r[2]  <= cfg_wdata;
        CFG_ACCEL_OFF_X: accel_off_r[0] <= cfg_wdata;
        CFG_ACCEL_OFF_Y: accel_off_r[1] <= cfg_wdata;
        CFG_ACCEL_OFF_Z: accel_off_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // board-mount rotation x'=y, y'=-x, z'=z plus offsets
  assign gsum[0] = CAL_W'(in_raw_gyro_y) + CAL_W'(gyro_off_r[0]);
  assign gsum[1] = -CAL_W'(in_raw_gyro_x) + CAL_W'(gyro_off_r[1]);
  assign gsum[2] = CAL_W'(in_raw_gyro_z) + CAL_W'(gyro_off_r[2]);
  assign asum[0] = CAL_W'(in_raw_accel_y) + CAL_W'(accel_off_r[0]);
  assign asum[1] = -CAL_W'(in_raw_accel_x) + CAL_W'(accel_off_r[1]);
  assign asum[2] = CAL_W'(in_raw_accel_z) + CAL_W'(accel_off_r[2]);

  // calibration stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        gcal_r[i] <= FIELD_W'(sat_sample(gsum[i], SAMPLE_WIDTH));
        acal_r[i] <= sat_sample(asum[i], SAMPLE_WIDTH);
      end
    end
  end

  // per-axis low-pass filters
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lpf
    imucal_lpf #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_lpf (
      .clk      (clk),
      .ctl      (lpf_ctl),
      .cal_in   (acal_r[g]),
      .filt_out (filt[g])
    );
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      primed_r    <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (lpf_ctl.upd) begin
        primed_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lpf_ctl.upd) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        gout_r[i] <= gcal_r[i];
        aout_r[i] <= acal_r[i][FIELD_W-1:0];
        fout_r[i] <= filt[i];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cal_gyro_x   = gout_r[0];
  assign out_cal_gyro_y   = gout_r[1];
  assign out_cal_gyro_z   = gout_r[2];
  assign out_cal_accel_x  = aout_r[0];
  assign out_cal_accel_y  = aout_r[1];
  assign out_cal_accel_z  = aout_r[2];
  assign out_filt_accel_x = fout_r[0];
  assign out_filt_accel_y = fout_r[1];
  assign out_filt_accel_z = fout_r[2];

endmodule

// ===== test/imucal_sample_checker.sv =====
`timescale 1ns / 100ps

module imucal_sample_checker
  import imucal_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_idx,
  input  logic [FIELD_W-1:0]        cfg_wdata,

  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [FIELD_W-1:0] in_raw_gyro_x,
  input  logic signed [FIELD_W-1:0] in_raw_gyro_y,
  input  logic signed [FIELD_W-1:0] in_raw_gyro_z,
  input  logic signed [FIELD_W-1:0] in_raw_accel_x,
  input  logic signed [FIELD_W-1:0] in_raw_accel_y,
  input  logic signed [FIELD_W-1:0] in_raw_accel_z,

  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [FIELD_W-1:0] out_cal_gyro_x,
  input  logic signed [FIELD_W-1:0] out_cal_gyro_y,
  input  logic signed [FIELD_W-1:0] out_cal_gyro_z,
  input  logic signed [FIELD_W-1:0] out_cal_accel_x,
  input  logic signed [FIELD_W-1:0] out_cal_accel_y,
  input  logic signed [FIELD_W-1:0] out_cal_accel_z,
  input  logic signed [FIELD_W-1:0] out_filt_accel_x,
  input  logic signed [FIELD_W-1:0] out_filt_accel_y,
  input  logic signed [FIELD_W-1:0] out_filt_accel_z,

  output int                        fail_count,
  output int                        pending,
  output int                        checked
);

  // saturation width of the instantiated block (default parameter)
  localparam int SAMPLE_W = SAMPLE_WIDTH_DEF;

  typedef struct packed {
    logic [FIELD_W-1:0] cal_gyro_x, cal_gyro_y, cal_gyro_z;
    logic [FIELD_W-1:0] cal_accel_x, cal_accel_y, cal_accel_z;
    logic [FIELD_W-1:0] filt_accel_x, filt_accel_y, filt_accel_z;
  } imu_result_t;

  // shadow of the offset registers and the filter delay line
  logic signed [FIELD_W-1:0] gyro_ofs [NUM_AXES];
  logic signed [FIELD_W-1:0] accel_ofs [NUM_AXES];
  logic signed [STATE_W-1:0] lp_y1 [NUM_AXES];
  logic signed [STATE_W-1:0] lp_y2 [NUM_AXES];
  logic                      lp_primed;

  imu_result_t cal_results_due [$];
  imu_result_t due;
  int          bad_fields;
  int          results_seen;

  // clamp to w signed bits
  function automatic logic signed [95:0] clamp_to(input logic signed [95:0] v, input int w);
    logic signed [95:0] hi;
    hi = (96'sd1 <<< (w - 1)) - 96'sd1;
    if (v > hi) begin
      return hi;
    end
    if (v < -hi - 96'sd1) begin
      return -hi - 96'sd1;
    end
    return v;
  endfunction

  // rotate, add offsets, run the low-pass one step; advances the delay line
  function automatic imu_result_t calibrate_and_filter(
    input logic signed [FIELD_W-1:0] gx, gy, gz, ax, ay, az
  );
    imu_result_t        r;
    logic signed [95:0] cg [NUM_AXES];
    logic signed [95:0] ca [NUM_AXES];
    logic signed [95:0] fo [NUM_AXES];
    logic signed [95:0] acc;
    int                 i;
    // board mount: x' = y, y' = -x, z' = z
    cg[0] = clamp_to(96'(gy) + 96'(gyro_ofs[0]), SAMPLE_W);
    cg[1] = clamp_to(96'(gyro_ofs[1]) - 96'(gx), SAMPLE_W);
    cg[2] = clamp_to(96'(gz) + 96'(gyro_ofs[2]), SAMPLE_W);
    ca[0] = clamp_to(96'(ay) + 96'(accel_ofs[0]), SAMPLE_W);
    ca[1] = clamp_to(96'(accel_ofs[1]) - 96'(ax), SAMPLE_W);
    ca[2] = clamp_to(96'(az) + 96'(accel_ofs[2]), SAMPLE_W);
    for (i = 0; i < NUM_AXES; i++) begin
      if (!lp_primed) begin
        // first sample loads both delay stages, output passes through
        lp_y1[i] = STATE_W'(ca[i] <<< 16);
        lp_y2[i] = lp_y1[i];
        fo[i]    = ca[i];
      end else begin
        // exact Q18.62 sum, round half up to Q16.32
        acc = 96'(COEF_C0) * 96'(lp_y1[i]) + 96'(COEF_C1) * 96'(lp_y2[i])
            + 96'(COEF_C2) * (ca[i] <<< 16) + (96'sd1 <<< 29);
        lp_y2[i] = lp_y1[i];
        lp_y1[i] = STATE_W'(clamp_to(acc >>> 30, STATE_W));
        fo[i]    = clamp_to((96'(lp_y1[i]) + 96'sd32768) >>> 16, SAMPLE_W);
      end
    end
    lp_primed = 1'b1;
    r.cal_gyro_x   = cg[0][FIELD_W-1:0];
    r.cal_gyro_y   = cg[1][FIELD_W-1:0];
    r.cal_gyro_z   = cg[2][FIELD_W-1:0];
    r.cal_accel_x  = ca[0][FIELD_W-1:0];
    r.cal_accel_y  = ca[1][FIELD_W-1:0];
    r.cal_accel_z  = ca[2][FIELD_W-1:0];
    r.filt_accel_x = fo[0][FIELD_W-1:0];
    r.filt_accel_y = fo[1][FIELD_W-1:0];
    r.filt_accel_z = fo[2][FIELD_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
      bad_fields++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        gyro_ofs[i]  = '0;
        accel_ofs[i] = '0;
        lp_y1[i]     = '0;
        lp_y2[i]     = '0;
      end
      lp_primed = 1'b0;
      cal_results_due.delete();
    end else begin
      // register writes, indexes past the last register do nothing
      if (cfg_we) begin
        if (cfg_idx <= CFG_GYRO_OFF_Z) begin
          gyro_ofs[2'(cfg_idx - CFG_GYRO_OFF_X)] = cfg_wdata;
        end else if (cfg_idx <= CFG_ACCEL_OFF_Z) begin
          accel_ofs[2'(cfg_idx - CFG_ACCEL_OFF_X)] = cfg_wdata;
        end
      end

      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (cal_results_due.size() == 0) begin
          $error("result beat with no sample outstanding");
          bad_fields++;
        end else begin
          due = cal_results_due.pop_front();
          check_field("cal_gyro_x", due.cal_gyro_x, out_cal_gyro_x);
          check_field("cal_gyro_y", due.cal_gyro_y, out_cal_gyro_y);
          check_field("cal_gyro_z", due.cal_gyro_z, out_cal_gyro_z);
          check_field("cal_accel_x", due.cal_accel_x, out_cal_accel_x);
          check_field("cal_accel_y", due.cal_accel_y, out_cal_accel_y);
          check_field("cal_accel_z", due.cal_accel_z, out_cal_accel_z);
          check_field("filt_accel_x", due.filt_accel_x, out_filt_accel_x);
          check_field("filt_accel_y", due.filt_accel_y, out_filt_accel_y);
          check_field("filt_accel_z", due.filt_accel_z, out_filt_accel_z);
          results_seen++;
        end
      end

      // input beat
      if (in_valid && !in_stall) begin
        cal_results_due.push_back(calibrate_and_filter(in_raw_gyro_x, in_raw_gyro_y,
          in_raw_gyro_z, in_raw_accel_x, in_raw_accel_y, in_raw_accel_z));
      end
    end
    fail_count <= bad_fields;
    pending    <= cal_results_due.size();
    checked    <= results_seen;
  end

endmodule

// ===== test/imu_calibrate_and_lowpass_tb.sv =====
`timescale 1ns / 100ps

module imu_calibrate_and_lowpass_tb
  import imucal_pkg::*;
();

  localparam logic [FIELD_W-1:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] S_MIN = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] ONE_G = 32'h0009_CE81;
  localparam int RAND_PHASES     = 8;
  localparam int PHASE_SAMPLES   = 210;
  localparam int HOLD_CYCLES     = 150;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 4;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx = '0;
  logic [FIELD_W-1:0]        cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [FIELD_W-1:0] in_raw_gyro_x = '0;
  logic signed [FIELD_W-1:0] in_raw_gyro_y = '0;
  logic signed [FIELD_W-1:0] in_raw_gyro_z = '0;
  logic signed [FIELD_W-1:0] in_raw_accel_x = '0;
  logic signed [FIELD_W-1:0] in_raw_accel_y = '0;
  logic signed [FIELD_W-1:0] in_raw_accel_z = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [FIELD_W-1:0] out_cal_gyro_x;
  logic signed [FIELD_W-1:0] out_cal_gyro_y;
  logic signed [FIELD_W-1:0] out_cal_gyro_z;
  logic signed [FIELD_W-1:0] out_cal_accel_x;
  logic signed [FIELD_W-1:0] out_cal_accel_y;
  logic signed [FIELD_W-1:0] out_cal_accel_z;
  logic signed [FIELD_W-1:0] out_filt_accel_x;
  logic signed [FIELD_W-1:0] out_filt_accel_y;
  logic signed [FIELD_W-1:0] out_filt_accel_z;

  int fail_count;
  int pending;
  int checked;

  int               sent = 0;
  int               settings = 0;
  int               holds = 0;
  bit               gaps_on = 1'b1;
  bit               stalls_on = 1'b1;
  bit               hold_now = 1'b0;
  logic [FIELD_W-1:0] ofs_plan [6];
  logic [FIELD_W-1:0] axis_base [6];

  imu_calibrate_and_lowpass i_dut (.*);

  imucal_sample_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return S_MAX;
      2: return S_MIN;
      3, 4, 5: return $urandom;
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  // slowly wandering sensor level with noise, plus occasional extremes
  function automatic logic [FIELD_W-1:0] pick_sample(input int axis);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return S_MAX;
    end else if (r == 1) begin
      return S_MIN;
    end else if (r <= 5) begin
      return $urandom;
    end
    if ($urandom_range(0, 49) == 0) begin
      axis_base[axis] = 32'($urandom_range(0, 32'h0050_0000)) - 32'h0028_0000;
    end
    return axis_base[axis] + 32'($urandom_range(0, 16383)) - 32'd8192;
  endfunction

  // one sample beat, then an optional gap
  task automatic send_sample(input logic [FIELD_W-1:0] gx, gy, gz, ax, ay, az);
    int gap;
    in_valid       <= 1'b1;
    in_raw_gyro_x  <= gx;
    in_raw_gyro_y  <= gy;
    in_raw_gyro_z  <= gz;
    in_raw_accel_x <= ax;
    in_raw_accel_y <= ay;
    in_raw_accel_z <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    gap = gaps_on ? pick_idle() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    send_sample(pick_sample(0), pick_sample(1), pick_sample(2),
                pick_sample(3), pick_sample(4), pick_sample(5));
  endtask

  // stop offering and let every outstanding result come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // load all offsets from ofs_plan, then hit the unused indexes
  task automatic program_offsets();
    int i;
    for (i = CFG_GYRO_OFF_X; i <= CFG_ACCEL_OFF_Z; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= ofs_plan[i];
      @(posedge clk);
    end
    for (i = CFG_ACCEL_OFF_Z + 1; i < (1 << CFG_IDX_W); i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // receiver: runs of accept and stall, long hold-off on request
  initial begin : receiver
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_now = 1'b0;
        holds++;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_idle() + 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int p;
    int k;
    for (k = 0; k < 6; k++) begin
      axis_base[k] = '0;
    end
    axis_base[5] = ONE_G;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // offsets at reset value: priming sample with negated most-negative input
    send_sample(S_MIN, S_MAX, '0, S_MIN, S_MAX, ONE_G);
    send_sample('0, '0, '0, '0, '0, '0);
    send_sample('1, '1, '1, '1, '1, '1);
    send_sample(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    // full-scale steps to push the filter into its rails
    repeat (4) send_sample(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX);
    repeat (3) send_sample(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN);
    send_sample(S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX);
    drain();

    // largest offsets: positive overflow
    for (k = 0; k < 6; k++) begin
      ofs_plan[k] = S_MAX;
    end
    program_offsets();
    send_sample(S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MAX);
    send_sample(S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, S_MIN);
    send_sample('0, '0, '0, '0, '0, '0);
    drain();

    // most negative offsets: negative overflow
    for (k = 0; k < 6; k++) begin
      ofs_plan[k] = S_MIN;
    end
    program_offsets();
    send_sample(S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, S_MIN);
    send_sample(S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MAX);
    send_sample('0, '0, '0, '0, '0, '0);
    drain();

    // random phases, each with fresh offsets and its own idle pattern
    for (p = 0; p < RAND_PHASES; p++) begin
      for (k = 0; k < 6; k++) begin
        ofs_plan[k] = pick_offset();
      end
      program_offsets();
      gaps_on   = (p % 3) != 2;
      stalls_on = (p % 3) != 2;
      if (p == 1 || p == 5) begin
        // back-to-back samples against a long receiver hold-off
        gaps_on  = 1'b0;
        hold_now = 1'b1;
      end
      repeat (PHASE_SAMPLES) send_random();
      drain();
    end

    $display("covered %0d samples across %0d offset settings, %0d results compared",
             sent, settings, checked);
    $display("receiver held off %0d times for %0d cycles while samples kept coming",
             holds, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
